// ===== rtl/tkst_pkg.sv =====
// Package for the top-k score table: payload types, command codes, slot type and per-cell control type.
`default_nettype none
package tkst_pkg;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_CHECK  = 2'd1,
    CMD_READ   = 2'd2
  } tkst_cmd_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [30:0] score;
    logic [7:0]  level;
    logic [3:0]  rank;
  } tkst_in_t;

  typedef struct packed {
    logic        ok_flag;
    logic [3:0]  position;
    logic [30:0] entry_score;
    logic [7:0]  entry_level;
    logic [3:0]  filled;
  } tkst_out_t;

  typedef struct packed {
    logic [30:0] score;
    logic [7:0]  level;
  } tkst_slot_t;

  // Per-cell control from the top level.
  typedef struct packed {
    logic ins;       // accepted insert transaction this cycle
    logic occupied;  // cell index below the fill count
    logic rank_hit;  // read rank addresses this cell
  } tkst_ctrl_t;

endpackage
`default_nettype wire

// ===== rtl/tkst_cell.sv =====
// One compare-and-shift cell of the sorted score chain.
`default_nettype none
module tkst_cell
  import tkst_pkg::*;
(
  input  wire logic       clk_i,
  input  wire tkst_ctrl_t ctrl_i,
  input  wire tkst_slot_t new_slot_i,
  input  wire tkst_slot_t prev_slot_i,
  input  wire logic       prev_keep_i,
  output logic            keep_o,
  output logic            place_o,
  output tkst_slot_t      slot_o,
  output tkst_slot_t      rd_slot_o
);

  tkst_slot_t slot_q, slot_d;

  // Held entry stays put when it ranks at or above the new score.
  assign keep_o  = ctrl_i.occupied && (slot_q.score >= new_slot_i.score);
  assign place_o = prev_keep_i && !keep_o;

  always_comb begin
    slot_d = slot_q;
    if (ctrl_i.ins && !keep_o) begin
      slot_d = prev_keep_i ? new_slot_i : prev_slot_i;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

  // Held pair handed to the next cell down the chain.
  assign slot_o    = slot_q;
  assign rd_slot_o = (ctrl_i.rank_hit && ctrl_i.occupied) ? slot_q : '0;

endmodule
`default_nettype wire

// ===== rtl/top_k_score_table_unit.sv =====
// Top level: bounded sorted top-k score table built as a chain of cells.
// Throughput: one command per cycle unless output back-pressure stalls the input.
// Every cell compares and shifts in the same cycle; each result is registered in out_q.
// Input is taken whenever the output register is empty or being drained.
// Reset clears the fill count and the output valid; slot contents stay undefined
// until written and are never read before then.
`default_nettype none
module top_k_score_table_unit
  import tkst_pkg::*;
#(
  parameter int ENTRIES = 10
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire tkst_in_t in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output tkst_out_t     out_data_o
);

  localparam int CW = $clog2(ENTRIES + 1);

  logic [CW-1:0] count_q, count_d;
  logic          out_valid_q;
  tkst_out_t     out_q, out_d;

  logic                     in_fire;
  logic [ENTRIES-1:0]       keep;
  logic [ENTRIES-1:0]       place;
  tkst_slot_t               rd_slot [ENTRIES];
  tkst_slot_t               cell_slot [ENTRIES];
  tkst_slot_t               new_slot;
  tkst_ctrl_t               ctrl [ENTRIES];
  logic                     is_insert;
  logic                     full;
  logic                     qual;
  logic [CW-1:0]            pos;
  logic [CW+3:0]            pos_ext;
  logic [CW+3:0]            cnt_ext;
  logic [CW+3:0]            rank_ext;
  logic [CW+3:0]            fill_ext;
  tkst_slot_t               rd_any;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign is_insert  = (in_data_i.command == CMD_INSERT);
  assign full       = (count_q == CW'(ENTRIES));
  assign new_slot   = '{score: in_data_i.score, level: in_data_i.level};
  assign rank_ext   = {{CW{1'b0}}, in_data_i.rank};

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    logic prev_keep;
    tkst_slot_t prev_slot;
    if (i == 0) begin : g_head
      assign prev_keep = 1'b1;
      assign prev_slot = new_slot;
    end else begin : g_body
      assign prev_keep = keep[i-1];
      assign prev_slot = cell_slot[i-1];
    end
    assign ctrl[i].ins      = in_fire && is_insert;
    assign ctrl[i].occupied = (count_q > CW'(i));
    assign ctrl[i].rank_hit = (rank_ext == (CW+4)'(i));

    tkst_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl[i]),
      .new_slot_i  (new_slot),
      .prev_slot_i (prev_slot),
      .prev_keep_i (prev_keep),
      .keep_o      (keep[i]),
      .place_o     (place[i]),
      .slot_o      (cell_slot[i]),
      .rd_slot_o   (rd_slot[i])
    );
  end

  // Keep bits form a thermometer; the new pair lands at the first cell not kept.
  assign qual = !keep[ENTRIES-1];

  always_comb begin
    pos    = CW'(ENTRIES);
    rd_any = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (place[i]) begin
        pos = CW'(i);
      end
      rd_any = rd_any | rd_slot[i];
    end
  end

  assign pos_ext = {4'b0, pos};

  always_comb begin
    count_d  = count_q;
    out_d    = '0;
    case (in_data_i.command)
      CMD_INSERT: begin
        out_d.ok_flag  = qual;
        out_d.position = pos_ext[3:0];
        if (qual && !full) begin
          count_d = count_q + CW'(1);
        end
      end
      CMD_CHECK: begin
        out_d.ok_flag = qual;
      end
      CMD_READ: begin
        if (rank_ext < cnt_ext) begin
          out_d.ok_flag     = 1'b1;
          out_d.entry_score = rd_any.score;
          out_d.entry_level = rd_any.level;
        end
      end
      default: begin
      end
    endcase
    fill_ext     = {4'b0, count_d};
    out_d.filled = fill_ext[3:0];
  end

  assign cnt_ext = {4'b0, count_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(ENTRIES))
    else $error("fill count exceeds table depth");

  a_one_place: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(place))
    else $error("more than one insertion point in the chain");

  a_count_inc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && is_insert && qual && !full) |=> (count_q == $past(count_q) + CW'(1)))
    else $error("kept insert into a non-full table did not grow the count");

  a_count_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !is_insert) |=> (count_q == $past(count_q)))
    else $error("non-insert transaction changed the fill count");

endmodule
`default_nettype wire
